[rtl/slpi_pkg.sv]
// Shared types, constants and the sine table generator of the pose integrator.
package slpi_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;

  localparam logic [14:0] VEL_STEP_RST  = 15'd5;
  localparam logic [14:0] TURN_STEP_RST = 15'd10;
  localparam logic [19:0] TICK_US_RST   = 20'd10000;

  localparam logic [1:0] CFG_VEL_STEP  = 2'd0;
  localparam logic [1:0] CFG_TURN_STEP = 2'd1;
  localparam logic [1:0] CFG_TICK_US   = 2'd2;

  // Heading scale, round(2^55 / (pi * 1e9)).
  localparam logic [23:0] HEAD_K = 24'd11468322;

  // Position step divisor is 2^18 * 125; the 2^18 part is a shift and the division by 125
  // a multiplication by ceil(2^40 / 125), which is exact for dividends below 2^33.
  localparam logic [24:0] POS_ROUND = 25'd16384000;
  localparam logic [33:0] POS_RECIP = 34'd8796093023;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SET_POSE,
    OP_LOAD_CMD,
    OP_SLEW,
    OP_HPROD,
    OP_HMUL_LO,
    OP_HMUL_HI,
    OP_HEAD,
    OP_TRIG,
    OP_MUL1,
    OP_MUL2,
    OP_DIV,
    OP_ACC,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   axis;  // 0 works on x and cosine, 1 on y and sine
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLEW,
    ST_HPROD,
    ST_HMUL_LO,
    ST_HMUL_HI,
    ST_HEAD,
    ST_TRIG,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } ctrl_state_e;

  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sine in Q15 of a phase given in Q32 of a turn, by a truncating Taylor series.
  function automatic logic signed [16:0] sine_entry(input longint unsigned ph);
    longint unsigned quad;
    longint unsigned frac;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned q15;
    quad = (ph >> 30) & 64'd3;
    frac = ph & (ONE_Q30 - 64'd1);
    if (quad == 64'd1 || quad == 64'd3) begin
      frac = ONE_Q30 - frac;
    end
    x  = (frac * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q15 = (s + 64'd16384) >> 15;
    if (quad >= 64'd2) begin
      return -$signed(q15[16:0]);
    end
    return $signed(q15[16:0]);
  endfunction

endpackage

[rtl/slpi_ctrl.sv]
// Sequencer of the pose integrator: handshakes and datapath commands.
module slpi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic                 s_axis_tuser,   // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output slpi_pkg::dp_cmd_t    cmd_o,
  input  slpi_pkg::dp_status_t status_i
);

  slpi_pkg::ctrl_state_e state_q, state_d;
  logic axis_q, axis_d;
  logic valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slpi_pkg::ST_IDLE;
      axis_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = (state_q == slpi_pkg::ST_IDLE);
  assign m_axis_tvalid = valid_q;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    valid_d   = valid_q;
    cmd_o.op  = slpi_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    if (valid_q && m_axis_tready) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      slpi_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          axis_d = 1'b0;
          if (s_axis_tuser) begin
            cmd_o.op = slpi_pkg::OP_SET_POSE;
            state_d  = slpi_pkg::ST_DONE;
          end else begin
            cmd_o.op = slpi_pkg::OP_LOAD_CMD;
            state_d  = slpi_pkg::ST_SLEW;
          end
        end
      end
      slpi_pkg::ST_SLEW: begin
        cmd_o.op = slpi_pkg::OP_SLEW;
        state_d  = slpi_pkg::ST_HPROD;
      end
      slpi_pkg::ST_HPROD: begin
        cmd_o.op = slpi_pkg::OP_HPROD;
        state_d  = slpi_pkg::ST_HMUL_LO;
      end
      slpi_pkg::ST_HMUL_LO: begin
        cmd_o.op = slpi_pkg::OP_HMUL_LO;
        state_d  = slpi_pkg::ST_HMUL_HI;
      end
      slpi_pkg::ST_HMUL_HI: begin
        cmd_o.op = slpi_pkg::OP_HMUL_HI;
        state_d  = slpi_pkg::ST_HEAD;
      end
      slpi_pkg::ST_HEAD: begin
        cmd_o.op = slpi_pkg::OP_HEAD;
        state_d  = slpi_pkg::ST_TRIG;
      end
      slpi_pkg::ST_TRIG: begin
        cmd_o.op = slpi_pkg::OP_TRIG;
        state_d  = slpi_pkg::ST_MUL1;
      end
      slpi_pkg::ST_MUL1: begin
        cmd_o.op = slpi_pkg::OP_MUL1;
        state_d  = slpi_pkg::ST_MUL2;
      end
      slpi_pkg::ST_MUL2: begin
        cmd_o.op = slpi_pkg::OP_MUL2;
        state_d  = slpi_pkg::ST_DIV;
      end
      slpi_pkg::ST_DIV: begin
        cmd_o.op = slpi_pkg::OP_DIV;
        if (status_i.div_last) begin
          state_d = slpi_pkg::ST_ACC;
        end
      end
      slpi_pkg::ST_ACC: begin
        cmd_o.op = slpi_pkg::OP_ACC;
        if (axis_q) begin
          state_d = slpi_pkg::ST_DONE;
        end else begin
          axis_d  = 1'b1;
          state_d = slpi_pkg::ST_TRIG;
        end
      end
      slpi_pkg::ST_DONE: begin
        // The result register is free or is being emptied in this cycle.
        if (!valid_q || m_axis_tready) begin
          cmd_o.op = slpi_pkg::OP_RESULT;
          valid_d  = 1'b1;
          state_d  = slpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slpi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/slpi_datapath.sv]
// Datapath of the pose integrator: state, slew, heading, trig table and position steps.
module slpi_datapath #(
  parameter int unsigned SINE_TABLE_DEPTH = slpi_pkg::SINE_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [19:0]          cfg_data_i,
  input  logic [111:0]         in_data_i,
  input  slpi_pkg::dp_cmd_t    cmd_i,
  output slpi_pkg::dp_status_t status_o,
  output logic [111:0]         out_data_o,
  output logic                 out_sat_o
);

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH);

  logic [14:0] vel_step_q;
  logic [14:0] turn_step_q;
  logic [19:0] tick_q;

  logic signed [31:0] pos_x_q;
  logic signed [31:0] pos_y_q;
  logic [15:0]        head_q;
  logic signed [15:0] vel_q;
  logic signed [15:0] turn_q;
  logic signed [15:0] cmd_vel_q;
  logic signed [15:0] cmd_turn_q;
  logic               clip_q;

  logic               hneg_q;
  logic [34:0]        hmag_q;
  logic [58:0]        hacc_q;
  logic signed [16:0] trig_q;
  logic signed [32:0] pv_q;
  logic               psign_q;
  logic [32:0]        dvd_q;
  logic [66:0]        dacc_q;
  logic               div_cnt_q;
  logic [111:0]       out_data_q;
  logic               out_sat_q;

  // Constant sine table, built at elaboration.
  logic signed [16:0] rom_w [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned Ph = (longint'(g) << 32) / SINE_TABLE_DEPTH;
    assign rom_w[g] = slpi_pkg::sine_entry(Ph);
  end

  function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                              input logic signed [15:0] tgt,
                                              input logic [14:0] step);
    logic signed [17:0] up;
    logic signed [17:0] dn;
    up = 18'(cur) + $signed({3'b000, step});
    dn = 18'(cur) - $signed({3'b000, step});
    if (tgt > cur) begin
      return (up >= 18'(tgt)) ? tgt : up[15:0];
    end else if (tgt < cur) begin
      return (dn <= 18'(tgt)) ? tgt : dn[15:0];
    end
    return cur;
  endfunction

  logic signed [36:0] hprod;
  logic [41:0]        hmul_lo;
  logic [40:0]        hmul_hi;
  logic [59:0]        hround;
  logic [15:0]        hdelta;
  logic [15:0]        trig_head;
  logic [31:0]        idx_full;
  logic [IdxW-1:0]    idx;
  logic signed [53:0] pprod;
  logic [52:0]        pmag;
  logic [52:0]        pround;
  logic [49:0]        dmul;
  logic [33:0]        dstep;
  logic signed [33:0] psum;
  logic signed [31:0] pos_sel;
  logic signed [31:0] pos_new;
  logic               pos_ovf;

  always_comb begin
    hprod     = $signed(turn_q) * $signed({1'b0, tick_q});
    hmul_lo   = hmag_q[17:0] * slpi_pkg::HEAD_K;
    hmul_hi   = hmag_q[34:18] * slpi_pkg::HEAD_K;
    hround    = {1'b0, hacc_q} + (60'd1 << 39);
    hdelta    = hround[55:40];
    trig_head = cmd_i.axis ? head_q : head_q + 16'd16384;
    idx_full  = 32'(trig_head) * 32'(SINE_TABLE_DEPTH);
    idx_full  = idx_full >> 16;
    idx       = (idx_full >= 32'(SINE_TABLE_DEPTH)) ? IdxW'(SINE_TABLE_DEPTH - 1)
                                                    : idx_full[IdxW-1:0];
    pprod     = pv_q * $signed({1'b0, tick_q});
    pmag      = pprod[53] ? 53'(-pprod) : pprod[52:0];
    pround    = pmag + 53'(slpi_pkg::POS_ROUND);
    // Division by 125 as a reciprocal multiplication, one half of the constant per cycle.
    dmul      = div_cnt_q ? dvd_q * slpi_pkg::POS_RECIP[33:17]
                          : dvd_q * slpi_pkg::POS_RECIP[16:0];
    dstep     = psign_q ? -(34'(dacc_q[66:40])) : 34'(dacc_q[66:40]);
    pos_sel   = cmd_i.axis ? pos_y_q : pos_x_q;
    psum      = 34'(pos_sel) + $signed(dstep);
    pos_ovf   = (psum[33:31] != 3'b000) && (psum[33:31] != 3'b111);
    if (!pos_ovf) begin
      pos_new = psum[31:0];
    end else if (psum[33]) begin
      pos_new = 32'sh8000_0000;
    end else begin
      pos_new = 32'sh7fff_ffff;
    end
  end

  assign status_o.div_last = div_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_step_q  <= slpi_pkg::VEL_STEP_RST;
      turn_step_q <= slpi_pkg::TURN_STEP_RST;
      tick_q      <= slpi_pkg::TICK_US_RST;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      vel_q       <= '0;
      turn_q      <= '0;
      clip_q      <= 1'b0;
      div_cnt_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          slpi_pkg::CFG_VEL_STEP:  vel_step_q  <= cfg_data_i[14:0];
          slpi_pkg::CFG_TURN_STEP: turn_step_q <= cfg_data_i[14:0];
          slpi_pkg::CFG_TICK_US:   tick_q      <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (cmd_i.op)
        slpi_pkg::OP_SET_POSE: begin
          pos_x_q <= in_data_i[63:32];
          pos_y_q <= in_data_i[95:64];
          head_q  <= in_data_i[111:96];
          clip_q  <= 1'b0;
        end
        slpi_pkg::OP_LOAD_CMD: clip_q <= 1'b0;
        slpi_pkg::OP_SLEW: begin
          vel_q  <= slew(vel_q, cmd_vel_q, vel_step_q);
          turn_q <= slew(turn_q, cmd_turn_q, turn_step_q);
        end
        slpi_pkg::OP_HEAD: head_q <= hneg_q ? head_q - hdelta : head_q + hdelta;
        slpi_pkg::OP_MUL2: div_cnt_q <= 1'b0;
        slpi_pkg::OP_DIV:  div_cnt_q <= !div_cnt_q;
        slpi_pkg::OP_ACC: begin
          if (cmd_i.axis) begin
            pos_y_q <= pos_new;
          end else begin
            pos_x_q <= pos_new;
          end
          if (pos_ovf) begin
            clip_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the working stages and the result.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      slpi_pkg::OP_LOAD_CMD: begin
        cmd_vel_q  <= in_data_i[15:0];
        cmd_turn_q <= in_data_i[31:16];
      end
      slpi_pkg::OP_HPROD: begin
        hneg_q <= hprod[36];
        hmag_q <= hprod[36] ? 35'(-hprod) : hprod[34:0];
      end
      slpi_pkg::OP_HMUL_LO: hacc_q <= 59'(hmul_lo);
      slpi_pkg::OP_HMUL_HI: hacc_q <= hacc_q + {hmul_hi, 18'd0};
      slpi_pkg::OP_TRIG:    trig_q <= rom_w[idx];
      slpi_pkg::OP_MUL1:    pv_q   <= vel_q * trig_q;
      slpi_pkg::OP_MUL2: begin
        psign_q <= pprod[53];
        dvd_q   <= pround[50:18];
      end
      slpi_pkg::OP_DIV: begin
        if (!div_cnt_q) begin
          dacc_q <= 67'(dmul);
        end else begin
          dacc_q <= dacc_q + {dmul, 17'd0};
        end
      end
      slpi_pkg::OP_RESULT: begin
        out_data_q <= {turn_q, vel_q, head_q, pos_y_q, pos_x_q};
        out_sat_q  <= clip_q;
      end
      default: ;
    endcase
  end

  assign out_data_o = out_data_q;
  assign out_sat_o  = out_sat_q;

endmodule

[rtl/slew_limited_pose_integrator_core.sv]
// Top level of the slew-limited pose integrator.
// A tick runs slew, heading product, two heading multiplies and the heading update, then per
// axis trig lookup, two multiplies, a division by 125 as a reciprocal multiply and the add,
// then the result. A set pose goes straight to the result. A new item is accepted only in
// idle, after the previous one, also while its result waits in the output register.
// Reset clears pose and velocities and loads the step registers with their defaults.
module slew_limited_pose_integrator_core #(
  parameter int unsigned SINE_TABLE_DEPTH = slpi_pkg::SINE_TABLE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [19:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd_vel, cmd_turn, new_x, new_y, new_heading
  input  logic [111:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_heading, out_vel, out_turn
  output logic [111:0] m_axis_tdata,
  // pos_saturated
  output logic         m_axis_tuser
);

  slpi_pkg::dp_cmd_t    cmd;
  slpi_pkg::dp_status_t status;

  slpi_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  slpi_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata),
    .out_sat_o  (m_axis_tuser)
  );

endmodule

[tb/slew_limited_pose_integrator_core_tb.sv]
// Testbench of the slew-limited pose integrator: a bit-true predictor checks every result.
`timescale 1ns / 100ps

module slew_limited_pose_integrator_core_tb;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam longint unsigned POS_SCALE = 64'd32768000;

  typedef struct packed {
    logic        kind;
    logic [15:0] cmd_vel;
    logic [15:0] cmd_turn;
    logic [31:0] new_x;
    logic [31:0] new_y;
    logic [15:0] new_heading;
  } pose_cmd_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
    logic [15:0] vel;
    logic [15:0] turn;
    logic        sat;
  } pose_out_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [19:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tuser;

  slew_limited_pose_integrator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  // Predictor state and configuration.
  int               sine_lut [TABLE_DEPTH];
  logic signed [31:0] px, py;
  logic [15:0]      hdg;
  logic signed [15:0] cur_vel, cur_turn;
  int unsigned      vstep = 5, tstep = 10, tick = 10000;

  pose_cmd_t pending_cmds [$];
  pose_out_t expected_poses [$];
  int        errors = 0;
  int        n_results = 0;
  int        n_sat = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Acceptance of the input seen at the last rising edge.
  logic s_axis_tready_seen = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s at result %0d: got %0d, want %0d", what, n_results, got, want);
    errors++;
  endtask

  task automatic enqueue_cmd(input pose_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic logic signed [15:0] slew_to(input logic signed [15:0] cur,
                                                 input logic signed [15:0] cmd,
                                                 input int unsigned stp);
    int c, t, n;
    c = cur;
    t = cmd;
    n = c;
    if (t > c) begin
      n = c + int'(stp);
      if (n >= t) n = t;
    end else if (t < c) begin
      n = c - int'(stp);
      if (n <= t) n = t;
    end
    return n[15:0];
  endfunction

  function automatic longint round_div(input longint num, input longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int lut_sin(input logic [16:0] h);
    int unsigned idx;
    idx = (int'(h[15:0]) * TABLE_DEPTH) >> 16;
    return sine_lut[idx];
  endfunction

  function automatic logic signed [31:0] clip_add(input logic signed [31:0] a,
                                                  input longint d, inout logic sat);
    longint s;
    s = longint'(a) + d;
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (s < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return s[31:0];
  endfunction

  task automatic build_sine_lut();
    longint unsigned ph, quad, frac, x, x2, t, s, q;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ph = (longint'(i) << 32) / TABLE_DEPTH;
      quad = (ph >> 30) & 3;
      frac = ph & (slpi_pkg::ONE_Q30 - 1);
      if (quad == 1 || quad == 3) frac = slpi_pkg::ONE_Q30 - frac;
      x  = (frac * slpi_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = slpi_pkg::ONE_Q30 - x2 / 110;
      t  = slpi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = slpi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = slpi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = slpi_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      q  = (s + 16384) >> 15;
      sine_lut[i] = (quad >= 2) ? -int'(q) : int'(q);
    end
  endtask

  task automatic predict_pose(input pose_cmd_t c);
    pose_out_t r;
    logic sat;
    longint p, d, cv, sv;
    longint unsigned mag, dm;
    sat = 1'b0;
    if (c.kind) begin
      px = c.new_x;
      py = c.new_y;
      hdg = c.new_heading;
    end else begin
      cur_vel = slew_to(cur_vel, c.cmd_vel, vstep);
      cur_turn = slew_to(cur_turn, c.cmd_turn, tstep);
      p = longint'(cur_turn) * longint'(tick);
      mag = (p < 0) ? -p : p;
      dm = (mag * 64'd11468322 + (64'd1 << 39)) >> 40;
      d = (p < 0) ? -longint'(dm) : longint'(dm);
      hdg = hdg + d[15:0];
      cv = lut_sin({1'b0, hdg} + 17'd16384);
      sv = lut_sin({1'b0, hdg});
      px = clip_add(px, round_div(longint'(cur_vel) * cv * longint'(tick), POS_SCALE), sat);
      py = clip_add(py, round_div(longint'(cur_vel) * sv * longint'(tick), POS_SCALE), sat);
    end
    r.x = px;
    r.y = py;
    r.heading = hdg;
    r.vel = cur_vel;
    r.turn = cur_turn;
    r.sat = sat;
    expected_poses.insert(expected_poses.size(), r);
  endtask

  // Driver: presents queued commands at the falling edge, with random idle cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready_seen) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pose_cmd_t c;
          c = pending_cmds.pop_front();
          predict_pose(c);
          s_axis_tdata <= {c.new_heading, c.new_y, c.new_x, c.cmd_turn, c.cmd_vel};
          s_axis_tuser <= c.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;

  // Monitor: checks each output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pose_out_t w, g;
      g.x = m_axis_tdata[31:0];
      g.y = m_axis_tdata[63:32];
      g.heading = m_axis_tdata[79:64];
      g.vel = m_axis_tdata[95:80];
      g.turn = m_axis_tdata[111:96];
      g.sat = m_axis_tuser;
      if (expected_poses.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_poses.pop_front();
        if (g.x != w.x) report_mismatch("x", $signed(g.x), $signed(w.x));
        if (g.y != w.y) report_mismatch("y", $signed(g.y), $signed(w.y));
        if (g.heading != w.heading)
          report_mismatch("heading", $signed(g.heading), $signed(w.heading));
        if (g.vel != w.vel) report_mismatch("vel", $signed(g.vel), $signed(w.vel));
        if (g.turn != w.turn) report_mismatch("turn", $signed(g.turn), $signed(w.turn));
        if (g.sat != w.sat) report_mismatch("saturated", g.sat, w.sat);
        if (w.sat) n_sat++;
      end
      n_results++;
    end
  end

  function automatic pose_cmd_t tick_cmd(input int v, input int t);
    pose_cmd_t c;
    c = '0;
    c.kind = 1'b0;
    c.cmd_vel = v[15:0];
    c.cmd_turn = t[15:0];
    c.new_x = $urandom;
    c.new_y = $urandom;
    c.new_heading = $urandom;
    return c;
  endfunction

  function automatic pose_cmd_t pose_cmd(input logic [31:0] x, input logic [31:0] y,
                                         input logic [15:0] h);
    pose_cmd_t c;
    c = '0;
    c.kind = 1'b1;
    c.cmd_vel = $urandom;
    c.cmd_turn = $urandom;
    c.new_x = x;
    c.new_y = y;
    c.new_heading = h;
    return c;
  endfunction

  function automatic pose_cmd_t random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 8) return pose_cmd($urandom, $urandom, $urandom);
    if (r < 14) return pose_cmd($urandom_range(1, 0) ? 32'h7fff0000 + $urandom_range(65535)
                                : 32'h80000000 + $urandom_range(65535),
                                $urandom, $urandom);
    if (r < 40) return tick_cmd($urandom_range(65535), $urandom_range(65535));
    return tick_cmd($signed(16'($urandom_range(4000))) - 2000,
                    $signed(16'($urandom_range(20000))) - 10000);
  endfunction

  // Waits until the block is idle: queue empty, nothing outstanding, then a margin.
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_poses.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[19:0];
    case (idx)
      slpi_pkg::CFG_VEL_STEP:  vstep = val & 32'h7fff;
      slpi_pkg::CFG_TURN_STEP: tstep = val & 32'h7fff;
      slpi_pkg::CFG_TICK_US:   tick = val & 32'hfffff;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) enqueue_cmd(random_cmd());
    drain();
  endtask

  initial begin
    build_sine_lut();
    px = 0; py = 0; hdg = 0; cur_vel = 0; cur_turn = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default registers, field extremes and both kinds.
    enqueue_cmd(tick_cmd(32767, 32767));
    enqueue_cmd(tick_cmd(-32768, -32768));
    enqueue_cmd(pose_cmd(32'h7fffffff, 32'h80000000, 16'h8000));
    enqueue_cmd(tick_cmd(0, 0));
    enqueue_cmd(pose_cmd(32'hffffffff, 32'h0, 16'h7fff));
    enqueue_cmd(pose_cmd(32'h0, 32'hffffffff, 16'hffff));
    drain();
    // Large steps and the longest tick drive positions into the limits.
    write_reg(slpi_pkg::CFG_VEL_STEP, 32767);
    write_reg(slpi_pkg::CFG_TURN_STEP, 32767);
    write_reg(slpi_pkg::CFG_TICK_US, 1000000);
    write_reg(2'd3, 12345);
    enqueue_cmd(pose_cmd(32'h7ff00000, 32'h7ff00000, 16'h2000));
    enqueue_cmd(tick_cmd(32767, 0));
    enqueue_cmd(tick_cmd(32767, 0));
    enqueue_cmd(pose_cmd(32'h80100000, 32'h80100000, 16'ha000));
    enqueue_cmd(tick_cmd(32767, 0));
    enqueue_cmd(tick_cmd(-32768, 32767));
    enqueue_cmd(tick_cmd(32767, -32768));
    drain();
    // Zero steps freeze the velocities; zero tick freezes the pose.
    write_reg(slpi_pkg::CFG_VEL_STEP, 0);
    write_reg(slpi_pkg::CFG_TURN_STEP, 0);
    write_reg(slpi_pkg::CFG_TICK_US, 0);
    enqueue_cmd(tick_cmd(100, -100));
    enqueue_cmd(tick_cmd(-32768, 32767));
    drain();
    write_reg(slpi_pkg::CFG_TICK_US, 1);
    enqueue_cmd(tick_cmd(0, 0));
    drain();

    write_reg(slpi_pkg::CFG_VEL_STEP, 5);
    write_reg(slpi_pkg::CFG_TURN_STEP, 10);
    write_reg(slpi_pkg::CFG_TICK_US, 10000);
    run_random(450, 0, 0);
    write_reg(slpi_pkg::CFG_VEL_STEP, 300);
    write_reg(slpi_pkg::CFG_TURN_STEP, 2000);
    write_reg(slpi_pkg::CFG_TICK_US, 100000);
    run_random(400, 87, 0);
    write_reg(slpi_pkg::CFG_VEL_STEP, 32767);
    write_reg(slpi_pkg::CFG_TURN_STEP, 1);
    write_reg(slpi_pkg::CFG_TICK_US, 1000000);
    run_random(400, 0, 87);
    write_reg(slpi_pkg::CFG_VEL_STEP, $urandom_range(32767));
    write_reg(slpi_pkg::CFG_TURN_STEP, $urandom_range(32767));
    write_reg(slpi_pkg::CFG_TICK_US, $urandom_range(1000000, 1));
    run_random(300, 34, 34);
    write_reg(slpi_pkg::CFG_TICK_US, 20000);
    run_random(300, 0, 0);

    $display("checked %0d results over five register settings and four idling phases", n_results);
    $display("%0d results had a clipped position", n_sat);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("slew_limited_pose_integrator_core_tb: PASS");
    end else begin
      $display("slew_limited_pose_integrator_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("timeout after %0d results", n_results);
    $display("slew_limited_pose_integrator_core_tb: FAIL");
    $finish;
  end

endmodule
